/* rtl/vrd_pkg.sv */
package vrd_pkg;

   // default depth of the rotation chain
   localparam int DEF_CORDIC_STAGES = 24;

   // interface field widths
   localparam int COORD_W = 32;
   localparam int ANGLE_W = 16;

   // datapath widths: Q16.16 scaled by the gain, plus guard fraction bits and headroom
   localparam int GUARD_BITS = 16;
   localparam int DATA_W     = 50;
   localparam int ZANG_W     = 34;
   localparam int ATAN_W     = 30;

   // angle reduction, 1/64 degree units
   localparam int RED_W        = 15;
   localparam int REM_W        = 13;
   localparam int FULL_TURN    = 23040;
   localparam int QUARTER_TURN = 5760;

   // gain compensation, 0.60725293 in Q30
   localparam logic [30:0] GAIN_Q30   = 31'd652032874;
   localparam int          GAIN_SHIFT = 30 - GUARD_BITS;
   localparam int          PROD_W     = 64;

   // remainder to binary angle: z = floor((r * 2^23 + 22) / 45)
   localparam int          ZFRAC_DIV   = 45;
   localparam int          ZFRAC_SHIFT = 23;
   localparam int          ZFRAC_BIAS  = 22;
   localparam int          QUOT_W      = 7;
   localparam int          RR_W        = 6;
   localparam logic [14:0] RECIP_DIV   = 15'd23302;
   localparam int          RECIP_SHIFT = 20;
   localparam int          RECIP_PW    = REM_W + 15;

   typedef logic [ZFRAC_DIV-1:0][ZFRAC_SHIFT-1:0] zfrac_lut_type;

   // fractional part of the binary angle for each remainder below the divisor
   function automatic zfrac_lut_type build_zfrac_lut();
      zfrac_lut_type lut;
      longint        v;
      for (int k = 0; k < ZFRAC_DIV; k++) begin
         v = ((longint'(k) << ZFRAC_SHIFT) + ZFRAC_BIAS) / ZFRAC_DIV;
         lut[k] = v[ZFRAC_SHIFT-1:0];
      end
      return lut;
   endfunction

   localparam zfrac_lut_type ZFRAC_LUT = build_zfrac_lut();

   // arctangent of 2^-i, full turn = 2^32
   function automatic logic [ATAN_W-1:0] atan_val(input int unsigned idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         0:       v = 30'd536870912;
         1:       v = 30'd316933406;
         2:       v = 30'd167458907;
         3:       v = 30'd85004756;
         4:       v = 30'd42667331;
         5:       v = 30'd21354465;
         6:       v = 30'd10679838;
         7:       v = 30'd5340245;
         8:       v = 30'd2670163;
         9:       v = 30'd1335087;
         10:      v = 30'd667544;
         11:      v = 30'd333772;
         12:      v = 30'd166886;
         13:      v = 30'd83443;
         14:      v = 30'd41722;
         15:      v = 30'd20861;
         16:      v = 30'd10430;
         17:      v = 30'd5215;
         18:      v = 30'd2608;
         19:      v = 30'd1304;
         20:      v = 30'd652;
         21:      v = 30'd326;
         22:      v = 30'd163;
         23:      v = 30'd81;
         24:      v = 30'd41;
         25:      v = 30'd20;
         26:      v = 30'd10;
         27:      v = 30'd5;
         28:      v = 30'd3;
         29:      v = 30'd1;
         30:      v = 30'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // one slot of the rotation chain
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [ZANG_W-1:0] z;
   } cell_data_type;

endpackage

/* rtl/vrd_prep.sv */
module vrd_prep
   import vrd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      req_valid,
   input  logic signed [COORD_W-1:0] req_x_in,
   input  logic signed [COORD_W-1:0] req_y_in,
   input  logic signed [ANGLE_W-1:0] req_angle_deg,
   output cell_data_type             prep_out
);

   typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quad_type;

   localparam logic signed [ANGLE_W:0] FULL_S  = (ANGLE_W+1)'(FULL_TURN);
   localparam logic signed [ANGLE_W:0] FULL2_S = (ANGLE_W+1)'(2 * FULL_TURN);
   localparam logic [RED_W-1:0] Q1_LIM = RED_W'(QUARTER_TURN);
   localparam logic [RED_W-1:0] Q2_LIM = RED_W'(2 * QUARTER_TURN);
   localparam logic [RED_W-1:0] Q3_LIM = RED_W'(3 * QUARTER_TURN);
   localparam logic signed [PROD_W-1:0] GAIN_HALF = PROD_W'(1) << (GAIN_SHIFT - 1);

   // stage 1: negate and reduce the angle into one turn
   logic                      s1_valid_ff;
   logic signed [COORD_W-1:0] s1_x_ff, s1_y_ff;
   logic [RED_W-1:0]          s1_a_ff, s1_a_in;
   logic signed [ANGLE_W:0]   neg_ang;
   logic signed [ANGLE_W:0]   a_wide;

   assign neg_ang = -$signed({req_angle_deg[ANGLE_W-1], req_angle_deg});

   always_comb begin
      if (neg_ang < -FULL_S) begin
         a_wide = neg_ang + FULL2_S;
      end else if (neg_ang < 0) begin
         a_wide = neg_ang + FULL_S;
      end else if (neg_ang >= FULL_S) begin
         a_wide = neg_ang - FULL_S;
      end else begin
         a_wide = neg_ang;
      end
      s1_a_in = a_wide[RED_W-1:0];
   end

   // stage 2: exact quarter-turn pre-rotation and remainder
   logic                      s2_valid_ff;
   logic signed [COORD_W:0]   s2_x_ff, s2_y_ff, s2_x_in, s2_y_in;
   logic [REM_W-1:0]          s2_r_ff, s2_r_in;
   logic signed [COORD_W:0]   x_ext, y_ext;
   logic [RED_W-1:0]          r_wide;
   quad_type                  quad;

   assign x_ext = {s1_x_ff[COORD_W-1], s1_x_ff};
   assign y_ext = {s1_y_ff[COORD_W-1], s1_y_ff};

   always_comb begin
      if (s1_a_ff >= Q3_LIM) begin
         quad   = QUAD_270;
         r_wide = s1_a_ff - Q3_LIM;
      end else if (s1_a_ff >= Q2_LIM) begin
         quad   = QUAD_180;
         r_wide = s1_a_ff - Q2_LIM;
      end else if (s1_a_ff >= Q1_LIM) begin
         quad   = QUAD_90;
         r_wide = s1_a_ff - Q1_LIM;
      end else begin
         quad   = QUAD_0;
         r_wide = s1_a_ff;
      end
      s2_r_in = r_wide[REM_W-1:0];
      case (quad)
         QUAD_90: begin
            s2_x_in = -y_ext;
            s2_y_in = x_ext;
         end
         QUAD_180: begin
            s2_x_in = -x_ext;
            s2_y_in = -y_ext;
         end
         QUAD_270: begin
            s2_x_in = y_ext;
            s2_y_in = -x_ext;
         end
         default: begin
            s2_x_in = x_ext;
            s2_y_in = y_ext;
         end
      endcase
   end

   // stage 3: gain multiply and quotient of the remainder by the divisor
   logic                      s3_valid_ff;
   logic signed [PROD_W-1:0]  s3_px_ff, s3_py_ff, s3_px_in, s3_py_in;
   logic [REM_W-1:0]          s3_r_ff;
   logic [QUOT_W-1:0]         s3_qq_ff, s3_qq_in;
   logic signed [COORD_W:0]   gain_s;
   logic [RECIP_PW-1:0]       recip_prod;

   assign gain_s     = $signed({2'b00, GAIN_Q30});
   assign s3_px_in   = PROD_W'(s2_x_ff) * PROD_W'(gain_s);
   assign s3_py_in   = PROD_W'(s2_y_ff) * PROD_W'(gain_s);
   assign recip_prod = RECIP_PW'(s2_r_ff) * RECIP_PW'(RECIP_DIV);
   assign s3_qq_in   = recip_prod[RECIP_SHIFT +: QUOT_W];

   // stage 4: round the scaled components, build the binary angle
   cell_data_type            prep_ff, prep_in;
   logic signed [PROD_W-1:0] px_round, py_round;
   logic [REM_W-1:0]         qq_times, rr_full;
   logic [RR_W-1:0]          rr;

   assign px_round = (s3_px_ff + GAIN_HALF) >>> GAIN_SHIFT;
   assign py_round = (s3_py_ff + GAIN_HALF) >>> GAIN_SHIFT;
   assign qq_times = REM_W'(s3_qq_ff) * REM_W'(ZFRAC_DIV);
   assign rr_full  = s3_r_ff - qq_times;
   assign rr       = rr_full[RR_W-1:0];

   always_comb begin
      prep_in.valid = s3_valid_ff;
      prep_in.x     = px_round[DATA_W-1:0];
      prep_in.y     = py_round[DATA_W-1:0];
      prep_in.z     = $signed(ZANG_W'({s3_qq_ff, ZFRAC_LUT[rr]}));
   end

   // pipeline registers, all moving together
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         prep_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         prep_ff     <= prep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff  <= req_x_in;
         s1_y_ff  <= req_y_in;
         s1_a_ff  <= s1_a_in;
         s2_x_ff  <= s2_x_in;
         s2_y_ff  <= s2_y_in;
         s2_r_ff  <= s2_r_in;
         s3_px_ff <= s3_px_in;
         s3_py_ff <= s3_py_in;
         s3_r_ff  <= s2_r_ff;
         s3_qq_ff <= s3_qq_in;
      end
   end

   assign prep_out = prep_ff;

endmodule

/* rtl/vrd_cell.sv */
module vrd_cell
   import vrd_pkg::*;
#(
   parameter int STAGE_IDX = 0
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  cell_data_type up_data,
   output cell_data_type down_data
);

   localparam logic signed [ZANG_W-1:0] ATAN_STEP =
      $signed(ZANG_W'(atan_val(STAGE_IDX % 32)));

   cell_data_type            data_ff, data_in;
   logic signed [DATA_W-1:0] x_shr, y_shr;

   assign x_shr = $signed(up_data.x) >>> STAGE_IDX;
   assign y_shr = $signed(up_data.y) >>> STAGE_IDX;

   // one micro-rotation, direction from the sign of the residual angle
   always_comb begin
      data_in.valid = up_data.valid;
      if (!up_data.z[ZANG_W-1]) begin
         data_in.x = up_data.x - y_shr;
         data_in.y = up_data.y + x_shr;
         data_in.z = up_data.z - ATAN_STEP;
      end else begin
         data_in.x = up_data.x + y_shr;
         data_in.y = up_data.y - x_shr;
         data_in.z = up_data.z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (advance) begin
         data_ff <= data_in;
      end
   end

   assign down_data = data_ff;

endmodule

/* rtl/vrd_out.sv */
module vrd_out
   import vrd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cell_data_type             last_data,
   output logic                      advance,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_x_out,
   output logic signed [COORD_W-1:0] rsp_y_out,
   output logic                      rsp_overflow
);

   localparam logic signed [DATA_W-1:0] OUT_HALF = DATA_W'(1) << (GUARD_BITS - 1);
   localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // round off the guard bits and clamp to Q16.16, top bit flags a clamp
   function automatic logic [COORD_W:0] round_sat(input logic signed [DATA_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      logic [COORD_W:0]         res;
      r = (v + OUT_HALF) >>> GUARD_BITS;
      if (r[DATA_W-1:COORD_W-1] == {(DATA_W-COORD_W+1){r[DATA_W-1]}}) begin
         res = {1'b0, r[COORD_W-1:0]};
      end else if (r[DATA_W-1]) begin
         res = {1'b1, SAT_MIN};
      end else begin
         res = {1'b1, SAT_MAX};
      end
      return res;
   endfunction

   logic [COORD_W:0] x_sat, y_sat;
   logic             new_ovf;

   assign x_sat   = round_sat(last_data.x);
   assign y_sat   = round_sat(last_data.y);
   assign new_ovf = x_sat[COORD_W] | y_sat[COORD_W];

   // output register with one skid entry behind it
   logic                      out_valid_ff, skid_valid_ff;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;
   logic                      out_ovf_ff, skid_ovf_ff;
   logic                      take;

   assign take    = out_valid_ff & ~rsp_stall;
   assign advance = ~skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (last_data.valid) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_x_ff   <= skid_x_ff;
            out_y_ff   <= skid_y_ff;
            out_ovf_ff <= skid_ovf_ff;
         end
      end else if (last_data.valid) begin
         if (!out_valid_ff || take) begin
            out_x_ff   <= x_sat[COORD_W-1:0];
            out_y_ff   <= y_sat[COORD_W-1:0];
            out_ovf_ff <= new_ovf;
         end else begin
            skid_x_ff   <= x_sat[COORD_W-1:0];
            skid_y_ff   <= y_sat[COORD_W-1:0];
            skid_ovf_ff <= new_ovf;
         end
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_x_out    = out_x_ff;
   assign rsp_y_out    = out_y_ff;
   assign rsp_overflow = out_ovf_ff;

   // skid entry only ever sits behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   // skid fills only when the output was stalled
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid entry filled without a stalled output");

   // a flagged result carries a clamped component
   a_ovf_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         (rsp_x_out == SAT_MAX || rsp_x_out == SAT_MIN ||
          rsp_y_out == SAT_MAX || rsp_y_out == SAT_MIN))
      else $error("overflow flagged on an unclamped result");

endmodule

/* rtl/vector_rotate_degrees_top.sv */
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   req_x_in, req_y_in, req_angle_deg
// rsp_      out        rsp_valid/rsp_stall   rsp_x_out, rsp_y_out, rsp_overflow
//
// one transaction per cycle sustained unless rsp_stall holds the pipe; a request passes through
// four preparation stages, one register per rotation cell and one output register
// reset is synchronous and clears only the valid bits of the pipeline
// the whole pipe holds when the output register and its skid entry are both full;
// req_stall is a registered signal taken from the skid entry
module vector_rotate_degrees_top
   import vrd_pkg::*;
#(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_x_in,
   input  logic signed [COORD_W-1:0] req_y_in,
   input  logic signed [ANGLE_W-1:0] req_angle_deg,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_x_out,
   output logic signed [COORD_W-1:0] rsp_y_out,
   output logic                      rsp_overflow
);

   logic          advance;
   cell_data_type chain [CORDIC_STAGES+1];

   assign req_stall = ~advance;

   // angle reduction, quadrant pre-rotation, gain and binary angle
   vrd_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_valid     (req_valid),
      .req_x_in      (req_x_in),
      .req_y_in      (req_y_in),
      .req_angle_deg (req_angle_deg),
      .prep_out      (chain[0])
   );

   // row of rotation cells
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      vrd_cell #(
         .STAGE_IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .up_data   (chain[i]),
         .down_data (chain[i+1])
      );
   end

   // rounding, saturation and the output buffer
   vrd_out u_out (
      .clock        (clock),
      .reset        (reset),
      .last_data    (chain[CORDIC_STAGES]),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_x_out    (rsp_x_out),
      .rsp_y_out    (rsp_y_out),
      .rsp_overflow (rsp_overflow)
   );

endmodule

/* verif/tb_vector_rotate_degrees_top.sv */
`timescale 1ns / 100ps

module tb_vector_rotate_degrees_top;
   import vrd_pkg::*;

   localparam int STAGES      = DEF_CORDIC_STAGES;
   localparam int LATENCY     = STAGES + 5;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 500;

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      ovf;
   } rotated_vec_type;

   // arctangent of 2^-i, full turn = 2^32
   localparam longint ARCTAN_STEP [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0
   };

   // expected rotations in order of acceptance, checked against responses
   class rotation_scoreboard;
      rotated_vec_type pending_rotations[$];
      int              mismatches;
      int              accepted_reqs;
      int              checked_rsps;
      int              saturated_rsps;

      function new();
         mismatches     = 0;
         accepted_reqs  = 0;
         checked_rsps   = 0;
         saturated_rsps = 0;
      endfunction

      // add half an lsb then shift arithmetically
      function longint round_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint clamp_q(longint v, ref bit sat);
         if (v > Q_MAX) begin
            sat = 1'b1;
            return Q_MAX;
         end
         if (v < Q_MIN) begin
            sat = 1'b1;
            return Q_MIN;
         end
         return v;
      endfunction

      // clockwise rotation: quadrant pre-turn, gain, cordic, round and saturate
      function rotated_vec_type predict_rotation(logic signed [COORD_W-1:0] xi,
                                                 logic signed [COORD_W-1:0] yi,
                                                 logic signed [ANGLE_W-1:0] ai);
         longint          a, rem, x, y, z, dx, dy;
         int              quad, n;
         bit              sat;
         rotated_vec_type res;
         sat = 1'b0;
         a = (-longint'(ai)) % FULL_TURN;
         if (a < 0) a += FULL_TURN;
         quad = int'(a / QUARTER_TURN);
         rem  = a % QUARTER_TURN;
         case (quad)
            1: begin
               x = -longint'(yi);
               y = longint'(xi);
            end
            2: begin
               x = -longint'(xi);
               y = -longint'(yi);
            end
            3: begin
               x = longint'(yi);
               y = -longint'(xi);
            end
            default: begin
               x = longint'(xi);
               y = longint'(yi);
            end
         endcase
         z = ((rem <<< 32) + FULL_TURN / 2) / FULL_TURN;
         x = round_shift(x * longint'(GAIN_Q30), 30 - GUARD_BITS);
         y = round_shift(y * longint'(GAIN_Q30), 30 - GUARD_BITS);
         n = (STAGES > 32) ? 32 : STAGES;
         for (int i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= ARCTAN_STEP[i];
            end else begin
               x += dx;
               y -= dy;
               z += ARCTAN_STEP[i];
            end
         end
         res.x   = COORD_W'(clamp_q(round_shift(x, GUARD_BITS), sat));
         res.y   = COORD_W'(clamp_q(round_shift(y, GUARD_BITS), sat));
         res.ovf = sat;
         return res;
      endfunction

      function void note_request(logic signed [COORD_W-1:0] xi,
                                 logic signed [COORD_W-1:0] yi,
                                 logic signed [ANGLE_W-1:0] ai);
         pending_rotations.push_back(predict_rotation(xi, yi, ai));
         accepted_reqs++;
      endfunction

      function void check_response(logic signed [COORD_W-1:0] xo,
                                   logic signed [COORD_W-1:0] yo,
                                   logic ovf);
         rotated_vec_type exp_v;
         if (pending_rotations.size() == 0) begin
            if (mismatches < 10)
               $display("ERROR: response with nothing outstanding x=%0d y=%0d ovf=%0b",
                        xo, yo, ovf);
            mismatches++;
            return;
         end
         exp_v = pending_rotations.pop_front();
         checked_rsps++;
         if (exp_v.ovf) saturated_rsps++;
         if (xo !== exp_v.x || yo !== exp_v.y || ovf !== exp_v.ovf) begin
            if (mismatches < 10)
               $display("ERROR: response %0d exp x=%0d y=%0d ovf=%0b got x=%0d y=%0d ovf=%0b",
                        checked_rsps, exp_v.x, exp_v.y, exp_v.ovf, xo, yo, ovf);
            mismatches++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_x_in = '0;
   logic signed [COORD_W-1:0] req_y_in = '0;
   logic signed [ANGLE_W-1:0] req_angle_deg = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [COORD_W-1:0] rsp_x_out;
   logic signed [COORD_W-1:0] rsp_y_out;
   logic                      rsp_overflow;

   rotation_scoreboard board = new();
   int unsigned        cycle_count = 0;
   bit                 req_quiet = 1'b0;

   vector_rotate_degrees_top #(
      .CORDIC_STAGES(STAGES)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_x_in     (req_x_in),
      .req_y_in     (req_y_in),
      .req_angle_deg(req_angle_deg),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_x_out    (rsp_x_out),
      .rsp_y_out    (rsp_y_out),
      .rsp_overflow (rsp_overflow)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ERROR: timed out after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int draw_wait(bit quiet);
      return quiet ? 0 : int'($urandom_range(0, 10));
   endfunction

   // response side: random stall after each transaction, with calm spells
   int  rsp_hold = 0;
   int  rsp_seen = 0;
   bit  rsp_quiet = 1'b0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_response(rsp_x_out, rsp_y_out, rsp_overflow);
         rsp_seen++;
         if (rsp_seen % 40 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
         rsp_hold = draw_wait(rsp_quiet);
      end
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // drive one request transaction, called at a clock edge
   task automatic send_rotation(input logic signed [COORD_W-1:0] xv,
                                input logic signed [COORD_W-1:0] yv,
                                input logic signed [ANGLE_W-1:0] av);
      int gap;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_x_in      <= xv;
      req_y_in      <= yv;
      req_angle_deg <= av;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(xv, yv, av);
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return COORD_W'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      if (sel < 8) return COORD_W'($urandom);
      if (sel == 8) return COORD_W'(32'sh7FFF_FFFF - int'($urandom_range(0, 255)));
      return COORD_W'(32'sh8000_0000 + int'($urandom_range(0, 255)));
   endfunction

   function automatic logic signed [ANGLE_W-1:0] pick_angle();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 14) return ANGLE_W'(int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
      if (sel < 17) return ANGLE_W'($urandom);
      // exact multiples of 45 degrees, wrapped both ways
      return ANGLE_W'((int'($urandom_range(0, 16)) - 8) * (QUARTER_TURN / 2));
   endfunction

   // stimulus
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: quadrants, wrap beyond one turn, extremes and saturation
      send_rotation(32'sh0001_0000, 32'sh0000_0000, 16'sd0);
      send_rotation(32'sh0001_0000, 32'sh0000_0000, 16'sd5760);
      send_rotation(32'sh0001_0000, 32'sh0002_0000, -16'sd5760);
      send_rotation(32'sh0003_0000, -32'sh0001_0000, 16'sd11520);
      send_rotation(32'sh0001_0000, 32'sh0001_0000, 16'sd2880);
      send_rotation(32'sh0001_0000, 32'sh0001_0000, -16'sd2880);
      send_rotation(32'sh0001_0000, 32'sh0000_0000, 16'sd1);
      send_rotation(32'sh0001_0000, 32'sh0000_0000, -16'sd1);
      send_rotation(32'sh0001_0000, 32'sh0000_0000, 16'sd23040);
      send_rotation(32'sh0001_0000, 32'sh0000_0000, -16'sd23040);
      send_rotation(32'sh0001_0000, 32'sh0000_8000, 16'sh7FFF);
      send_rotation(32'sh0001_0000, 32'sh0000_8000, 16'sh8000);
      send_rotation(32'sh0000_0000, 32'sh0000_0000, 16'sd1234);
      send_rotation(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd2880);
      send_rotation(32'sh8000_0000, 32'sh8000_0000, -16'sd2880);
      send_rotation(32'sh8000_0000, 32'sh0000_0000, 16'sd11520);
      send_rotation(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd5760);
      send_rotation(32'sh8000_0000, 32'sh7FFF_FFFF, -16'sd17280);
      send_rotation(32'sh7FFF_FFFF, 32'sh0000_0000, 16'sd0);
      send_rotation(32'shFFFF_FFFF, 32'sh0000_0001, 16'sd17279);
      send_rotation(32'sh5A82_7999, 32'shA57D_8667, 16'sd5759);
      send_rotation(32'shFFFF_FFFF, 32'shFFFF_FFFF, 16'shFFFF);

      // random traffic with occasional back-to-back spells
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) req_quiet = ($urandom_range(0, 3) == 0);
         send_rotation(pick_coord(), pick_coord(), pick_angle());
      end
      req_valid <= 1'b0;

      // drain
      while (board.pending_rotations.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("Covered %0d rotations (%0d saturated) over all quadrants, wrapped angles",
               board.checked_rsps, board.saturated_rsps);
      $display("and extreme coordinates, with random gaps and stalls on both sides");
      if (board.mismatches == 0 && board.pending_rotations.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("ERROR: %0d mismatches, %0d responses missing",
                  board.mismatches, board.pending_rotations.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/vrd_pkg.sv
rtl/vrd_prep.sv
rtl/vrd_cell.sv
rtl/vrd_out.sv
rtl/vector_rotate_degrees_top.sv
verif/tb_vector_rotate_degrees_top.sv
